// ----- sv/tts_pkg.sv -----
// Shared types and constants of the text tokenizer stream core.
// Holds the state and result beat records, phase codes and character codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

  localparam logic [2:0] PH_NORMAL    = 3'd0;
  localparam logic [2:0] PH_ESCAPE    = 3'd1;
  localparam logic [2:0] PH_PAIR      = 3'd2;
  localparam logic [2:0] PH_RFC_PAIR  = 3'd3;
  localparam logic [2:0] PH_RFC_CHECK = 3'd4;
  localparam logic [2:0] PH_RFC_SKIP  = 3'd5;

  localparam logic [1:0] MODE_WORD = 2'd0;
  localparam logic [1:0] MODE_LINE = 2'd1;
  localparam logic [1:0] MODE_RFC  = 2'd2;
  localparam logic [1:0] MODE_FULL = 2'd3;

  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_BRACKET = 1'b1;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  localparam logic ITEM_CHAR = 1'b0;
  localparam logic ITEM_END  = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSL    = 8'h5C;

  typedef struct packed {
    logic [2:0] phase;
    logic       peek_cr;
    logic [7:0] cur_sep;
    logic [7:0] prev_sep;
    logic       tok_ne;
    logic [3:0] tok_lvl;
  } state_t;

  typedef struct packed {
    logic       item_type;
    logic [7:0] token_char;
    logic [7:0] separator;
    logic [3:0] bracket_level;
    logic       stream_end;
    logic       last;
  } res_t;

  function automatic logic is_sep(input logic [7:0] c);
    case (c) inside
      8'h2C, 8'h3B, 8'h3A, 8'h2B, 8'h2D, 8'h3D, 8'h2F, 8'h5C, 8'h40: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] closer_of(input logic [7:0] c);
    case (c)
      8'h28:   return 8'h29;
      8'h5B:   return 8'h5D;
      8'h7B:   return 8'h7D;
      8'h3C:   return 8'h3E;
      default: return c;
    endcase
  endfunction

  function automatic logic is_open(input logic [7:0] c, input logic [1:0] mode);
    if (c == CH_DQUOTE) return 1'b1;
    if (mode != MODE_FULL) return 1'b0;
    return (c == 8'h28) || (c == 8'h5B) || (c == 8'h7B) || (c == 8'h3C);
  endfunction

endpackage

`default_nettype wire

// ----- sv/text_tokenizer_stream_core.sv -----
// Top level of the text tokenizer stream core: state, bracket stack and
// a two-entry result buffer around the combinational step in tts_step.
// Depends on tts_pkg and tts_step.
//
//   channel   dir  payload                                          beat rule
//   s_axis    in   tuser kind; tdata[7:0] ch                        tvalid & tready
//   m_axis    out  tuser item_type; tlast last; tdata: see port     tvalid & tready
//   cfg       in   cfg_addr_i 0 mode, 1 bracket_enable              cfg_we_i
//
// An input beat is processed in the cycle it is accepted and its results
// appear from the next cycle on, one per cycle while m_axis_tready is high.
// One input beat per cycle is sustained while each gives at most one result and
// m_axis_tready is high; two results hold s_axis_tready low until one is taken.
// Reset clears the tokenizer state and the buffer; the bracket stack memory
// is not cleared, and only entries below the current nesting depth are used.
`timescale 1ns / 1ps
`default_nettype none

module text_tokenizer_stream_core
  import tts_pkg::*;
#(
  parameter int STACK_DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [1:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  wire logic        s_axis_tuser,   // [0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] token_char, [15:8] separator,
                                           // [19:16] bracket_level, [20] stream_end
  output logic             m_axis_tuser,   // [0] item_type
  output logic             m_axis_tlast
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [1:0]    mode_q;
  logic          bracket_en_q;
  state_t        st_q, st_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [7:0]    top_q;
  logic [7:0]    rd_q;
  logic [7:0]    stack_mem [STACK_DEPTH];
  logic [1:0]    cnt_q;
  res_t          ent0_q, ent1_q;

  logic          push, pop;
  logic [7:0]    push_val;
  logic [1:0]    n_res;
  res_t          res0, res1;
  logic          in_acc, out_acc;
  logic [DW-1:0] rd_ptr;

  tts_step #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_step (
    .mode_i      (mode_q),
    .bracket_en_i(bracket_en_q),
    .kind_i      (s_axis_tuser),
    .ch_i        (s_axis_tdata),
    .st_i        (st_q),
    .depth_i     (depth_q),
    .top_i       (top_q),
    .st_o        (st_d),
    .depth_o     (depth_d),
    .push_o      (push),
    .push_val_o  (push_val),
    .pop_o       (pop),
    .n_o         (n_res),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  assign s_axis_tready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  assign m_axis_tdata = {3'd0, ent0_q.stream_end, ent0_q.bracket_level,
                         ent0_q.separator, ent0_q.token_char};
  assign m_axis_tuser = ent0_q.item_type;
  assign m_axis_tlast = ent0_q.last;

  assign rd_ptr = (in_acc ? depth_d : depth_q) - DW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_WORD;
      bracket_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MODE:    mode_q       <= cfg_wdata_i;
        REG_BRACKET: bracket_en_q <= cfg_wdata_i[0];
        default:     mode_q       <= mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '{phase: PH_NORMAL, peek_cr: 1'b0, cur_sep: CH_NUL,
                   prev_sep: CH_NUL, tok_ne: 1'b0, tok_lvl: 4'd0};
      depth_q <= '0;
      cnt_q   <= 2'd0;
    end else begin
      if (in_acc) begin
        st_q    <= st_d;
        depth_q <= depth_d;
        cnt_q   <= n_res;
      end else if (out_acc) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ent0_q <= res0;
      ent1_q <= res1;
    end else if (out_acc) begin
      ent0_q <= ent1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && push) begin
      stack_mem[depth_q[AW-1:0]] <= push_val;
    end
    rd_q <= stack_mem[rd_ptr[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && push) begin
      top_q <= push_val;
    end else if (in_acc && pop) begin
      top_q <= rd_q;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tts_step.sv -----
// Combinational next-state and result logic for one accepted item.
// Depends on tts_pkg; the bracket stack itself lives in the top level.
`timescale 1ns / 1ps
`default_nettype none

module tts_step
  import tts_pkg::*;
#(
  parameter int STACK_DEPTH = 8
) (
  input  wire logic [1:0]                         mode_i,
  input  wire logic                               bracket_en_i,
  input  wire logic                               kind_i,
  input  wire logic [7:0]                         ch_i,
  input  wire state_t                             st_i,
  input  wire logic [$clog2(STACK_DEPTH+1)-1:0]   depth_i,
  input  wire logic [7:0]                         top_i,
  output state_t                                  st_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]        depth_o,
  output logic                                    push_o,
  output logic [7:0]                              push_val_o,
  output logic                                    pop_o,
  output logic [1:0]                              n_o,
  output res_t                                    res0_o,
  output res_t                                    res1_o
);

  localparam int DW = $clog2(STACK_DEPTH + 1);

  function automatic res_t mk_end(input logic [7:0] sep, input logic [3:0] lvl,
                                  input logic eos);
    res_t r;
    r.item_type     = ITEM_END;
    r.token_char    = CH_NUL;
    r.separator     = sep;
    r.bracket_level = lvl;
    r.stream_end    = eos;
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_char(input logic [7:0] c);
    res_t r;
    r.item_type     = ITEM_CHAR;
    r.token_char    = c;
    r.separator     = CH_NUL;
    r.bracket_level = 4'd0;
    r.stream_end    = 1'b0;
    r.last          = 1'b0;
    return r;
  endfunction

  always_comb begin
    state_t        st;
    logic [DW-1:0] depth;
    logic [1:0]    n;
    res_t          r0;
    res_t          r1;
    res_t          beat;
    logic          run_proc;
    logic          emit;
    logic          may_end;
    logic [7:0]    partner;
    logic          sp_tab;
    logic          is_lf;

    st         = st_i;
    depth      = depth_i;
    n          = 2'd0;
    r0         = mk_char(CH_NUL);
    r1         = mk_char(CH_NUL);
    beat       = mk_char(CH_NUL);
    run_proc   = 1'b0;
    emit       = 1'b0;
    may_end    = 1'b0;
    push_o     = 1'b0;
    push_val_o = CH_NUL;
    pop_o      = 1'b0;
    partner    = st_i.peek_cr ? CH_CR : CH_LF;
    sp_tab     = (ch_i == CH_SPACE) || (ch_i == CH_TAB);
    is_lf      = (ch_i == CH_CR) || (ch_i == CH_LF);

    if (kind_i == KIND_EOS) begin
      st.phase    = PH_NORMAL;
      r0          = mk_end(st.cur_sep, st.tok_lvl, 1'b1);
      n           = 2'd1;
      st.prev_sep = st.cur_sep;
      st.tok_ne   = 1'b0;
    end else begin
      unique case (st_i.phase) inside
        PH_ESCAPE: begin
          st.phase  = PH_NORMAL;
          st.tok_ne = 1'b1;
          n         = 2'd1;
          if (depth != '0 && is_lf) begin
            st.peek_cr = (ch_i == CH_LF);
            st.phase   = PH_PAIR;
            r0         = mk_char(CH_LF);
          end else begin
            r0 = mk_char(ch_i);
          end
        end
        PH_PAIR: begin
          st.phase = PH_NORMAL;
          run_proc = (ch_i != partner);
        end
        PH_RFC_PAIR, PH_RFC_CHECK: begin
          if (st_i.phase == PH_RFC_PAIR && ch_i == partner) begin
            st.phase = PH_RFC_CHECK;
          end else if (sp_tab) begin
            st.phase = PH_RFC_SKIP;
          end else begin
            st.phase    = PH_NORMAL;
            r0          = mk_end(st.cur_sep, st.tok_lvl, 1'b0);
            n           = 2'd1;
            st.prev_sep = st.cur_sep;
            st.tok_ne   = 1'b0;
            run_proc    = 1'b1;
          end
        end
        PH_RFC_SKIP: begin
          if (!sp_tab) begin
            st.phase = PH_NORMAL;
            run_proc = 1'b1;
          end
        end
        default: begin
          st.phase = PH_NORMAL;
          run_proc = 1'b1;
        end
      endcase

      if (run_proc) begin
        may_end = (st.prev_sep != CH_SPACE) || st.tok_ne;
        if (ch_i == CH_BSL) begin
          st.phase = PH_ESCAPE;
        end else if (is_lf) begin
          st.cur_sep = CH_LF;
          st.peek_cr = (ch_i == CH_LF);
          if (mode_i == MODE_RFC) begin
            st.phase = PH_RFC_PAIR;
          end else begin
            st.phase = PH_PAIR;
            emit     = (mode_i != MODE_WORD) || may_end;
          end
        end else if (depth == '0 && (mode_i == MODE_WORD || mode_i == MODE_FULL) &&
                     sp_tab) begin
          if (st.tok_ne) begin
            st.cur_sep = CH_SPACE;
            emit       = 1'b1;
          end else begin
            st.prev_sep = CH_SPACE;
          end
        end else if (mode_i == MODE_FULL && is_sep(ch_i)) begin
          st.cur_sep = ch_i;
          emit       = may_end;
        end else if (depth != '0 && top_i == ch_i) begin
          st.tok_lvl = 4'(depth);
          depth      = depth - DW'(1);
          pop_o      = 1'b1;
          st.cur_sep = ch_i;
          emit       = 1'b1;
        end else if (bracket_en_i && depth < DW'(STACK_DEPTH) &&
                     (mode_i == MODE_WORD || mode_i == MODE_FULL) &&
                     is_open(ch_i, mode_i)) begin
          st.tok_lvl = 4'(depth);
          push_o     = 1'b1;
          push_val_o = closer_of(ch_i);
          depth      = depth + DW'(1);
          if (may_end) begin
            st.cur_sep = ch_i;
            emit       = 1'b1;
          end
        end else begin
          st.tok_ne = 1'b1;
          beat      = mk_char(ch_i);
          if (n == 2'd0) r0 = beat; else r1 = beat;
          n = n + 2'd1;
        end

        if (emit) begin
          beat        = mk_end(st.cur_sep, st.tok_lvl, 1'b0);
          st.prev_sep = st.cur_sep;
          st.tok_ne   = 1'b0;
          if (n == 2'd0) r0 = beat; else r1 = beat;
          n = n + 2'd1;
        end
      end
    end

    r0.last = (n == 2'd1);
    r1.last = 1'b1;

    st_o    = st;
    depth_o = depth;
    n_o     = n;
    res0_o  = r0;
    res1_o  = r1;
  end

endmodule

`default_nettype wire

// ----- test/tb_text_tokenizer_stream_core.sv -----
// Self-checking testbench for text_tokenizer_stream_core: random and directed character
// streams under every mode and bracket setting, with an in-bench tokenizer that predicts
// each output beat. Depends on tts_pkg and the core.
`timescale 1ns / 1ps

module tb_text_tokenizer_stream_core;
  import tts_pkg::*;

  localparam int NEST_MAX = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_RUNS = 9;
  localparam int CHARS_PER_RUN = 222;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } char_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = REG_MODE;
  logic [1:0]  cfg_wdata_i = MODE_WORD;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = KIND_CHAR;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  text_tokenizer_stream_core #(
    .STACK_DEPTH(NEST_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  char_item_t  chars_to_send[$];
  char_item_t  on_bus;
  res_t        token_beats_due[$];
  res_t        step_beats[$];
  res_t        seen_beat;
  res_t        due_beat;
  int          send_idle_pct = 16;
  int          recv_idle_pct = 62;
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  // Tokenizer state as the core should hold it.
  logic [1:0]  cfg_mode = MODE_WORD;
  logic        cfg_bracket = 1'b0;
  logic [2:0]  tk_phase = PH_NORMAL;
  logic        pair_wants_cr = 1'b0;
  logic [7:0]  sep_now = 8'h00;
  logic [7:0]  sep_before = 8'h00;
  logic        tok_has_text = 1'b0;
  logic [3:0]  depth = 4'd0;
  logic [7:0]  closers [NEST_MAX];
  logic [3:0]  end_level = 4'd0;

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic logic is_eol(logic [7:0] c);
    return c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic is_punct_sep(logic [7:0] c);
    return c == "," || c == ";" || c == ":" || c == "+" || c == "-" || c == "=" ||
           c == "/" || c == CH_BSL || c == "@";
  endfunction

  function automatic logic [7:0] closing_of(logic [7:0] c);
    case (c)
      "(":     return ")";
      "[":     return "]";
      "{":     return "}";
      "<":     return ">";
      default: return c;
    endcase
  endfunction

  function automatic void emit_char(logic [7:0] c);
    res_t r;
    r = '0;
    r.item_type = ITEM_CHAR;
    r.token_char = c;
    step_beats.push_back(r);
  endfunction

  function automatic void emit_end(logic eos);
    res_t r;
    r = '0;
    r.item_type = ITEM_END;
    r.separator = sep_now;
    r.bracket_level = end_level;
    r.stream_end = eos;
    step_beats.push_back(r);
    sep_before = sep_now;
    tok_has_text = 1'b0;
  endfunction

  function automatic void tokenize_char(logic [7:0] c);
    logic can_close;
    logic opens;
    can_close = (sep_before != CH_SPACE) || tok_has_text;
    if (c == CH_BSL) begin
      tk_phase = PH_ESCAPE;
      return;
    end
    if (is_eol(c)) begin
      sep_now = CH_LF;
      pair_wants_cr = (c == CH_LF);
      if (cfg_mode == MODE_RFC) begin
        tk_phase = PH_RFC_PAIR;
        return;
      end
      tk_phase = PH_PAIR;
      if (cfg_mode != MODE_WORD || can_close) emit_end(1'b0);
      return;
    end
    if (depth == 0 && (cfg_mode == MODE_WORD || cfg_mode == MODE_FULL) && is_blank(c)) begin
      if (tok_has_text) begin
        sep_now = CH_SPACE;
        emit_end(1'b0);
      end else begin
        sep_before = CH_SPACE;
      end
      return;
    end
    if (cfg_mode == MODE_FULL && is_punct_sep(c)) begin
      sep_now = c;
      if (can_close) emit_end(1'b0);
      return;
    end
    if (depth > 0 && closers[depth - 1] == c) begin
      end_level = depth;
      depth = depth - 4'd1;
      sep_now = c;
      emit_end(1'b0);
      return;
    end
    opens = (c == CH_DQUOTE) ||
            (cfg_mode == MODE_FULL && (c == "(" || c == "[" || c == "{" || c == "<"));
    if (cfg_bracket && depth < NEST_MAX && opens &&
        (cfg_mode == MODE_WORD || cfg_mode == MODE_FULL)) begin
      end_level = depth;
      closers[depth] = closing_of(c);
      depth = depth + 4'd1;
      if (can_close) begin
        sep_now = c;
        emit_end(1'b0);
      end
      return;
    end
    tok_has_text = 1'b1;
    emit_char(c);
  endfunction

  // Works out the output beats that one accepted input beat causes.
  function automatic void tokenize_item(logic kind, logic [7:0] c);
    logic [7:0] partner;
    partner = pair_wants_cr ? CH_CR : CH_LF;
    step_beats.delete();
    if (kind == KIND_EOS) begin
      tk_phase = PH_NORMAL;
      emit_end(1'b1);
    end else begin
      case (tk_phase) inside
        PH_ESCAPE: begin
          tk_phase = PH_NORMAL;
          tok_has_text = 1'b1;
          if (depth > 0 && is_eol(c)) begin
            pair_wants_cr = (c == CH_LF);
            tk_phase = PH_PAIR;
            emit_char(CH_LF);
          end else begin
            emit_char(c);
          end
        end
        PH_PAIR: begin
          tk_phase = PH_NORMAL;
          if (c != partner) tokenize_char(c);
        end
        PH_RFC_PAIR, PH_RFC_CHECK: begin
          if (tk_phase == PH_RFC_PAIR && c == partner) begin
            tk_phase = PH_RFC_CHECK;
          end else if (is_blank(c)) begin
            tk_phase = PH_RFC_SKIP;
          end else begin
            tk_phase = PH_NORMAL;
            emit_end(1'b0);
            tokenize_char(c);
          end
        end
        PH_RFC_SKIP: begin
          if (!is_blank(c)) begin
            tk_phase = PH_NORMAL;
            tokenize_char(c);
          end
        end
        default: begin
          tk_phase = PH_NORMAL;
          tokenize_char(c);
        end
      endcase
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    foreach (step_beats[i]) token_beats_due.push_back(step_beats[i]);
  endfunction

  function automatic logic [7:0] pick_char();
    string seps = ",;:+-=/@";
    string opens = "\"([{<";
    string shuts = "\")]}>";
    case ($urandom_range(15)) inside
      [0:3]:   return 8'("a" + $urandom_range(25));
      4:       return CH_SPACE;
      5:       return CH_TAB;
      6:       return CH_CR;
      7:       return CH_LF;
      8:       return CH_BSL;
      9:       return seps[$urandom_range(7)];
      10:      return opens[$urandom_range(4)];
      11:      return shuts[$urandom_range(4)];
      12:      return CH_NUL;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic count_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic queue_char(logic kind, logic [7:0] c);
    char_item_t it;
    it.kind = kind;
    it.ch = c;
    chars_to_send.push_back(it);
  endtask

  task automatic queue_text(string s);
    foreach (s[i]) queue_char(KIND_CHAR, s[i]);
  endtask

  task automatic write_reg(logic idx, logic [1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MODE) cfg_mode = val;
    else cfg_bracket = val[0];
  endtask

  // Beats that cause no output may still be in the core when the last output arrives.
  task automatic wait_idle();
    while (chars_to_send.size() != 0 || s_axis_tvalid || token_beats_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) tokenize_item(on_bus.kind, on_bus.ch);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = chars_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= on_bus.ch;
          s_axis_tuser <= on_bus.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_beat.item_type = m_axis_tuser;
        seen_beat.token_char = m_axis_tdata[7:0];
        seen_beat.separator = m_axis_tdata[15:8];
        seen_beat.bracket_level = m_axis_tdata[19:16];
        seen_beat.stream_end = m_axis_tdata[20];
        seen_beat.last = m_axis_tlast;
        if (token_beats_due.size() == 0) begin
          count_mismatch($sformatf({"unexpected beat: type %0d char %02h sep %02h ",
            "lvl %0d eos %0d last %0d"},
            seen_beat.item_type, seen_beat.token_char, seen_beat.separator,
            seen_beat.bracket_level, seen_beat.stream_end, seen_beat.last));
        end else begin
          due_beat = token_beats_due.pop_front();
          if (seen_beat.item_type !== due_beat.item_type ||
              seen_beat.token_char !== due_beat.token_char ||
              seen_beat.separator !== due_beat.separator ||
              seen_beat.bracket_level !== due_beat.bracket_level ||
              seen_beat.stream_end !== due_beat.stream_end ||
              seen_beat.last !== due_beat.last) begin
            count_mismatch($sformatf({"mismatch: expected type %0d char %02h sep %02h ",
              "lvl %0d eos %0d last %0d, got type %0d char %02h sep %02h lvl %0d ",
              "eos %0d last %0d"},
              due_beat.item_type, due_beat.token_char, due_beat.separator,
              due_beat.bracket_level, due_beat.stream_end, due_beat.last,
              seen_beat.item_type, seen_beat.token_char, seen_beat.separator,
              seen_beat.bracket_level, seen_beat.stream_end, seen_beat.last));
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int run;
    int sent;
    int burst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Word mode: whitespace end, a line end that is dropped after whitespace,
    // a CR/LF pair, NUL and all-ones bytes, then end of stream.
    write_reg(REG_MODE, MODE_WORD);
    write_reg(REG_BRACKET, 2'd0);
    queue_text("a \n");
    queue_char(KIND_CHAR, CH_NUL);
    queue_text("\r\n");
    queue_char(KIND_CHAR, 8'hFF);
    queue_char(KIND_EOS, 8'hFF);
    wait_idle();

    // Header folding, left with a line end pending across the mode change.
    write_reg(REG_MODE, MODE_RFC);
    queue_text("\r\n v\n");
    wait_idle();

    // Full mode with nesting: one opener past a full stack, an escaped line end
    // inside brackets, a separator and a closer.
    write_reg(REG_MODE, MODE_FULL);
    write_reg(REG_BRACKET, 2'd1);
    queue_text("(((((((((\\\r\n,)");
    queue_char(KIND_EOS, 8'h00);
    wait_idle();

    for (run = 0; run < RANDOM_RUNS; run++) begin
      if (run == RANDOM_RUNS / 3) begin
        send_idle_pct = 62;
        recv_idle_pct = 16;
      end else if (run == 2 * RANDOM_RUNS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_MODE, 2'(run % 4));
      write_reg(REG_BRACKET, 2'((run + run / 4) % 2));
      sent = 0;
      while (sent < CHARS_PER_RUN) begin
        if ($urandom_range(99) < 3) begin
          queue_char(KIND_EOS, 8'($urandom_range(255)));
          sent++;
        end else if ($urandom_range(99) < 2) begin
          for (burst = $urandom_range(10, 6); burst > 0; burst--) begin
            queue_char(KIND_CHAR, (cfg_mode == MODE_FULL) ? "(" : CH_DQUOTE);
            sent++;
          end
        end else begin
          queue_char(KIND_CHAR, pick_char());
          sent++;
        end
      end
      wait_idle();
    end

    if (mismatches == 0 && token_beats_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
